// ===== rtl/core/fwim_pkg.sv =====
// shared types, sizes and the weight code decoder for the fp4 weight matmul
// no dependencies; used by fwim_ctrl, fwim_dp and fp4_weight_int8_matmul
package fwim_pkg;

  localparam int unsigned ROWS  = 8;
  localparam int unsigned COLS  = 16;
  localparam int unsigned DEPTH = 64;
  localparam int unsigned PAIRS = (DEPTH + 1) / 2;

  localparam int unsigned ROW_W   = 3;
  localparam int unsigned COL_W   = 4;
  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned PAIR_W  = 5;
  localparam int unsigned ACT_W   = 8;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned WGT_W   = 5;
  localparam int unsigned PROD_W  = ACT_W + WGT_W;
  localparam int unsigned ACC_W   = 18;

  localparam int unsigned ACT_N = ROWS * DEPTH;
  localparam int unsigned WGT_N = PAIRS * COLS;
  localparam int unsigned ACT_AW = ROW_W + DEPTH_W;
  localparam int unsigned WGT_AW = PAIR_W + COL_W;

  typedef enum logic [1:0] {
    MODE_ACT = 2'd0,
    MODE_WGT = 2'd1,
    MODE_DOT = 2'd2
  } mode_e;

  typedef struct packed {
    logic               wr_act;
    logic               wr_wgt;
    logic               start;
    logic               issue;
    logic               load_out;
    logic [DEPTH_W-1:0] k;
  } cmd_t;

  // twice the e2m1 magnitude
  localparam logic [3:0] MAG_TWICE [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd12};

  function automatic logic signed [WGT_W-1:0] fwim_decode(input logic [3:0] code);
    logic signed [WGT_W-1:0] m;
    m = {1'b0, MAG_TWICE[code[2:0]]};
    return code[3] ? -m : m;
  endfunction

endpackage

// ===== rtl/core/fwim_ctrl.sv =====
// request sequencing for the fp4 weight matmul: state machine, depth counter,
// output valid flag; depends on fwim_pkg
module fwim_ctrl
  import fwim_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_mode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_LAST = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  localparam logic [DEPTH_W-1:0] K_LAST = DEPTH_W'(DEPTH - 1);

  state_e             state_q, state_d;
  logic [DEPTH_W-1:0] k_q, k_d;
  logic               out_valid_q, out_valid_d;
  logic               in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.k    = k_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (mode_e'(in_mode_i))
            MODE_ACT: cmd_o.wr_act = 1'b1;
            MODE_WGT: cmd_o.wr_wgt = 1'b1;
            MODE_DOT: begin
              cmd_o.start = 1'b1;
              k_d         = '0;
              state_d     = S_RUN;
            end
            default: ;  // unused mode is dropped
          endcase
        end
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        k_d         = k_q + 1'b1;
        if (k_q == K_LAST) state_d = S_LAST;
      end
      // last product accumulates here
      S_LAST: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.load_out)
    else $error("pending result overwritten");

  a_dot_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_mode_i == MODE_DOT) |=> (state_q == S_RUN && k_q == '0))
    else $error("compute request did not start depth walk at zero");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && k_q == K_LAST) |=> ##2 cmd_o.load_out || out_valid_q)
    else $error("depth walk did not reach result stage");

endmodule

// ===== rtl/core/fwim_dp.sv =====
// datapath for the fp4 weight matmul: activation and weight memories,
// code decode, multiply-accumulate and result register; depends on fwim_pkg
module fwim_dp
  import fwim_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic [ROW_W-1:0]         row_i,
  input  logic [COL_W-1:0]         col_i,
  input  logic [DEPTH_W-1:0]       depth_index_i,
  input  logic [PAIR_W-1:0]        pair_index_i,
  input  logic signed [ACT_W-1:0]  act_value_i,
  input  logic [CODE_W-1:0]        packed_codes_i,
  output logic signed [ACC_W-1:0]  dot_product_o
);

  logic [ACT_W-1:0]  act_mem [ACT_N];
  logic [CODE_W-1:0] wgt_mem [WGT_N];

  logic [ROW_W-1:0]        row_q;
  logic [COL_W-1:0]        col_q;
  logic [ACT_W-1:0]        act_rd_q;
  logic [CODE_W-1:0]       wgt_rd_q;
  logic                    odd_q;
  logic                    rd_vld_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] dot_q;

  logic [3:0]              code;
  logic signed [WGT_W-1:0] wgt;
  logic signed [PROD_W-1:0] prod;

  // memory writes; indexes always fall inside the stores at these sizes
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_act) act_mem[{row_i, depth_index_i}] <= act_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_wgt) wgt_mem[{pair_index_i, col_i}] <= packed_codes_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      row_q <= row_i;
      col_q <= col_i;
    end
  end

  // registered reads, one depth step per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      act_rd_q <= act_mem[{row_q, cmd_i.k}];
      wgt_rd_q <= wgt_mem[{cmd_i.k[DEPTH_W-1:1], col_q}];
      odd_q    <= cmd_i.k[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_vld_q <= 1'b0;
    else         rd_vld_q <= cmd_i.issue;
  end

  assign code = odd_q ? wgt_rd_q[7:4] : wgt_rd_q[3:0];
  assign wgt  = fwim_decode(code);
  assign prod = $signed(act_rd_q) * wgt;

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.start)   acc_d = '0;
    else if (rd_vld_q) acc_d = acc_q + ACC_W'(prod);
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.load_out) dot_q <= acc_q;
  end

  assign dot_product_o = dot_q;

endmodule

// ===== rtl/core/fp4_weight_int8_matmul.sv =====
// Matrix product of signed 8-bit activations with packed 4-bit e2m1 weight codes.
// Each request is a write of one activation (mode 0), a write of one packed
// weight byte (mode 1), or a dot product of one activation row with one weight
// column over the full depth of 64 (mode 2); mode 3 is dropped. Writes
// return nothing. A compute request walks the depth one multiply-accumulate
// per cycle, reading one activation and one weight byte per cycle from
// single-port memories; once the walk is done its result is loaded into the
// output register, later only while an earlier result still waits there,
// and the next request is taken once the result has been loaded into the
// output register. Reading memory entries never written gives an undefined
// result. Depends on fwim_pkg, fwim_ctrl and fwim_dp.
module fp4_weight_int8_matmul
  import fwim_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               in_mode_i,
  input  logic [ROW_W-1:0]         in_row_i,
  input  logic [COL_W-1:0]         in_col_i,
  input  logic [DEPTH_W-1:0]       in_depth_index_i,
  input  logic [PAIR_W-1:0]        in_pair_index_i,
  input  logic signed [ACT_W-1:0]  in_act_value_i,
  input  logic [CODE_W-1:0]        in_packed_codes_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ACC_W-1:0]  out_dot_product_o
);

  cmd_t cmd;

  fwim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_mode_i   (in_mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  fwim_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .row_i          (in_row_i),
    .col_i          (in_col_i),
    .depth_index_i  (in_depth_index_i),
    .pair_index_i   (in_pair_index_i),
    .act_value_i    (in_act_value_i),
    .packed_codes_i (in_packed_codes_i),
    .dot_product_o  (out_dot_product_o)
  );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for fp4_weight_int8_matmul: int8 activation rows times packed e2m1 weight columns
// depends on fwim_pkg and the fp4_weight_int8_matmul rtl; holds its own dot product predictor
`timescale 1ns / 100ps

module testbench;
  import fwim_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int N_ITEMS      = 1450;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam longint SUM_MAX  = 2**(ACC_W-1) - 1;
  localparam longint SUM_MIN  = -(2**(ACC_W-1));

  typedef struct {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [ACC_W-1:0] sum;
  } dot_exp_t;

  class dot_scoreboard;
    logic [ACT_W-1:0]  act_mem [ROWS][DEPTH];
    logic [CODE_W-1:0] wgt_mem [PAIRS][COLS];
    dot_exp_t expected_q [$];
    int mismatches;
    int results_seen;

    function new();
      foreach (act_mem[r, d]) act_mem[r][d] = '0;
      foreach (wgt_mem[p, c]) wgt_mem[p][c] = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    // e2m1 code to twice its value, bit 3 is the sign
    function int weight_twice(logic [3:0] code);
      int m;
      case (code[2:0])
        3'd0: m = 0;
        3'd1: m = 1;
        3'd2: m = 2;
        3'd3: m = 3;
        3'd4: m = 4;
        3'd5: m = 6;
        3'd6: m = 8;
        default: m = 12;
      endcase
      return code[3] ? -m : m;
    endfunction

    function logic signed [ACC_W-1:0] dot_row_col(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
      longint acc;
      logic [CODE_W-1:0] wb;
      logic [3:0] code;
      acc = 0;
      if (row < ROWS && col < COLS) begin
        for (int k = 0; k < DEPTH; k++) begin
          wb = wgt_mem[k / 2][col];
          code = (k % 2 == 1) ? wb[7:4] : wb[3:0];
          acc += longint'($signed(act_mem[row][k])) * weight_twice(code);
        end
      end
      if (acc > SUM_MAX) acc = SUM_MAX;
      if (acc < SUM_MIN) acc = SUM_MIN;
      return ACC_W'(acc);
    endfunction

    function void note_req(logic [1:0] mode, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic [DEPTH_W-1:0] d, logic [PAIR_W-1:0] p,
                           logic [ACT_W-1:0] act, logic [CODE_W-1:0] codes);
      dot_exp_t e;
      case (mode)
        MODE_ACT: if (row < ROWS && d < DEPTH) act_mem[row][d] = act;
        MODE_WGT: if (col < COLS && p < PAIRS) wgt_mem[p][col] = codes;
        MODE_DOT: begin
          e.row = row;
          e.col = col;
          e.sum = dot_row_col(row, col);
          expected_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [ACC_W-1:0] got);
      dot_exp_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: dot product %0d arrived with no request pending", got);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (got !== e.sum) begin
        if (mismatches < 10)
          $display("ERROR: dot(row %0d, col %0d) expected %0d, got %0d",
                   e.row, e.col, e.sum, got);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    req_valid = 1'b0;
  logic                    req_ready;
  logic [1:0]              req_mode = '0;
  logic [ROW_W-1:0]        req_row = '0;
  logic [COL_W-1:0]        req_col = '0;
  logic [DEPTH_W-1:0]      req_depth = '0;
  logic [PAIR_W-1:0]       req_pair = '0;
  logic signed [ACT_W-1:0] req_act = '0;
  logic [CODE_W-1:0]       req_codes = '0;
  logic                    res_valid;
  logic                    res_ready = 1'b0;
  logic signed [ACC_W-1:0] res_dot;

  dot_scoreboard board = new();

  int unsigned cycle_cnt = 0;
  int n_act = 0, n_wgt = 0, n_dot = 0, n_unused = 0;
  bit act_done [ROWS][DEPTH];
  bit wgt_done [PAIRS][COLS];

  fp4_weight_int8_matmul u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (req_valid),
    .in_ready_o        (req_ready),
    .in_mode_i         (req_mode),
    .in_row_i          (req_row),
    .in_col_i          (req_col),
    .in_depth_index_i  (req_depth),
    .in_pair_index_i   (req_pair),
    .in_act_value_i    (req_act),
    .in_packed_codes_i (req_codes),
    .out_valid_o       (res_valid),
    .out_ready_i       (res_ready),
    .out_dot_product_o (res_dot)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("fp4_weight_int8_matmul: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_valid && res_ready) board.check_result(res_dot);
  end

  // window where neither side idles
  function automatic bit quiet();
    return cycle_cnt >= 3000 && cycle_cnt < 7000;
  endfunction

  // result side: random stalls plus one long hold-off once traffic is flowing
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && board.results_seen >= 40) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= quiet() || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  task automatic send_req(input logic [1:0] mode, input logic [ROW_W-1:0] row,
                          input logic [COL_W-1:0] col, input logic [DEPTH_W-1:0] d,
                          input logic [PAIR_W-1:0] p, input logic [ACT_W-1:0] act,
                          input logic [CODE_W-1:0] codes);
    @(negedge clk);
    while (!quiet() && $urandom_range(0, 99) < 13) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_mode  <= mode;
    req_row   <= row;
    req_col   <= col;
    req_depth <= d;
    req_pair  <= p;
    req_act   <= act;
    req_codes <= codes;
    do @(posedge clk); while (!req_ready);
    board.note_req(mode, row, col, d, p, act, codes);
    case (mode)
      MODE_ACT: n_act++;
      MODE_WGT: n_wgt++;
      MODE_DOT: n_dot++;
      default:  n_unused++;
    endcase
  endtask

  task automatic idle_input();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  function automatic logic [ACT_W-1:0] rand_act();
    case ($urandom_range(0, 19))
      0: return 8'h80;
      1: return 8'h7f;
      2: return 8'h00;
      3: return 8'hff;
      default: return ACT_W'($urandom);
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] rand_codes();
    case ($urandom_range(0, 19))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h88;
      3: return 8'h77;
      4: return 8'hee;
      default: return CODE_W'($urandom);
    endcase
  endfunction

  task automatic write_act(input int r, input int d, input logic [ACT_W-1:0] v);
    send_req(MODE_ACT, ROW_W'(r), COL_W'($urandom), DEPTH_W'(d), PAIR_W'($urandom), v,
             CODE_W'($urandom));
    act_done[r][d] = 1'b1;
  endtask

  task automatic write_wgt(input int p, input int c, input logic [CODE_W-1:0] codes);
    send_req(MODE_WGT, ROW_W'($urandom), COL_W'(c), DEPTH_W'($urandom), PAIR_W'(p),
             ACT_W'($urandom), codes);
    wgt_done[p][c] = 1'b1;
  endtask

  task automatic dot_req(input int r, input int c);
    send_req(MODE_DOT, ROW_W'(r), COL_W'(c), DEPTH_W'($urandom), PAIR_W'($urandom),
             ACT_W'($urandom), CODE_W'($urandom));
  endtask

  task automatic unused_req();
    send_req(MODE_UNUSED, ROW_W'($urandom), COL_W'($urandom), DEPTH_W'($urandom),
             PAIR_W'($urandom), ACT_W'($urandom), CODE_W'($urandom));
  endtask

  function automatic bit row_full(input int r);
    for (int d = 0; d < DEPTH; d++)
      if (!act_done[r][d]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit col_full(input int c);
    for (int p = 0; p < PAIRS; p++)
      if (!wgt_done[p][c]) return 1'b0;
    return 1'b1;
  endfunction

  // write whatever is still missing, starting at a random depth
  task automatic fill_row(input int r);
    int start;
    int d;
    start = $urandom_range(0, DEPTH - 1);
    for (int i = 0; i < DEPTH; i++) begin
      d = (start + i) % DEPTH;
      if (!act_done[r][d]) write_act(r, d, rand_act());
    end
  endtask

  task automatic fill_col(input int c);
    int start;
    int p;
    start = $urandom_range(0, PAIRS - 1);
    for (int i = 0; i < PAIRS; i++) begin
      p = (start + i) % PAIRS;
      if (!wgt_done[p][c]) write_wgt(p, c, rand_codes());
    end
  endtask

  initial begin
    int r, c, r2, c2, n;
    bit paused;
    paused = 1'b0;
    foreach (act_done[i, j]) act_done[i][j] = 1'b0;
    foreach (wgt_done[i, j]) wgt_done[i][j] = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field extremes, negative zero and the unused mode
    write_act(0, 0, 8'h80);
    write_act(ROWS - 1, DEPTH - 1, 8'h7f);
    write_act(3, 31, 8'h00);
    write_act(5, 17, 8'hff);
    write_wgt(0, 0, 8'h88);
    write_wgt(PAIRS - 1, COLS - 1, 8'hff);
    write_wgt(16, 9, 8'h00);
    write_wgt(7, 4, 8'h7f);
    send_req(MODE_UNUSED, '1, '1, '1, '1, '1, '1);
    send_req(MODE_UNUSED, '0, '0, '0, '0, '0, '0);
    unused_req();

    // largest positive and negative sums, then an all negative-zero column
    for (int d = 0; d < DEPTH; d++) write_act(0, d, 8'h80);
    for (int p = 0; p < PAIRS; p++) write_wgt(p, 0, 8'hff);
    dot_req(0, 0);
    for (int p = 0; p < PAIRS; p++) write_wgt(p, 0, 8'h77);
    dot_req(0, 0);
    for (int p = 0; p < PAIRS; p++) write_wgt(p, 0, 8'h88);
    dot_req(0, 0);

    // random part: complete a row and a column, compute, then some noise
    while (n_act + n_wgt + n_dot < N_ITEMS) begin
      r = $urandom_range(0, ROWS - 1);
      c = $urandom_range(0, COLS - 1);
      fill_row(r);
      fill_col(c);
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
        r2 = r;
        c2 = c;
        for (int t = 0; t < 8; t++) begin
          int rr, cc;
          rr = $urandom_range(0, ROWS - 1);
          cc = $urandom_range(0, COLS - 1);
          if (row_full(rr) && col_full(cc)) begin
            r2 = rr;
            c2 = cc;
            break;
          end
        end
        dot_req(r2, c2);
      end
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 19))
          0, 1: unused_req();
          2, 3, 4, 5, 6, 7, 8, 9, 10:
            write_act($urandom_range(0, ROWS - 1), $urandom_range(0, DEPTH - 1), rand_act());
          default:
            write_wgt($urandom_range(0, PAIRS - 1), $urandom_range(0, COLS - 1),
                      rand_codes());
        endcase
      end
      // one pause until the pipeline has drained completely
      if (!paused && n_act + n_wgt + n_dot >= 700) begin
        paused = 1'b1;
        idle_input();
        while (board.pending() != 0) @(posedge clk);
      end
    end

    idle_input();
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests: %0d activation writes, %0d weight writes, %0d dot products",
             n_act, n_wgt, n_dot);
    $display("also %0d unused-mode requests; %0d results checked over %0d cycles",
             n_unused, board.results_seen, cycle_cnt);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("fp4_weight_int8_matmul: match");
    end else begin
      $display("%0d errors, %0d results still expected", board.mismatches, board.pending());
      $display("fp4_weight_int8_matmul: mismatch");
    end
    $finish;
  end

endmodule
